// File: src/dsa_pkg.sv
// Shared types, codes and constants of the descriptor slot allocator.
package dsa_pkg;

   // Built depth of the free stack, default for the top level
   localparam int HEAP_DEPTH_DEF = 4096;

   // Field widths
   localparam int LIMIT_W   = 13;
   localparam int STRIDE_W  = 16;
   localparam int ADDR_W64  = 64;
   localparam int SLOT_W    = 12;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_LIMIT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_STRIDE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CPU_BASE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GPU_BASE       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

   // Register reset values
   localparam logic [LIMIT_W-1:0]  SLOT_LIMIT_RST  = 13'd4096;
   localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = 16'd32;

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE_ACTIVE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNUSED      = 2'd3;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_ADD   = 3'b100
   } state_type;

endpackage

// File: src/dsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dsa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word into the registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/descriptor_slot_allocator.sv
// Top level of the descriptor slot allocator: bump index, LIFO free stack, address math.
//
// A command word is taken when start is high and busy is low. A free is answered in the
// cycle after it is taken and the block can take the next word in that same cycle.
// An allocate passes through the free stack memory read, the slot-times-stride multiply
// and the 64-bit base adds; its result strobes on rsp_valid in the same cycle in which
// start is accepted again. An allocate that finds the heap exhausted is answered like a
// free. Results are shown for exactly one cycle on the rsp_ ports and must be taken
// then, the receiver cannot hold them off. The free stack needs no clearing after
// reset, so the block is ready as soon as reset is released. The user must write
// configuration through csr_we/csr_index/csr_wdata only while no command is in flight;
// the block itself does not enforce it.
module descriptor_slot_allocator #(
   parameter int HEAP_DEPTH = dsa_pkg::HEAP_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // command side
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_cmd,
   input  logic [dsa_pkg::SLOT_W-1:0]      req_free_slot,
   // result side
   output logic                            rsp_valid,
   output logic [dsa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [dsa_pkg::SLOT_W-1:0]      rsp_slot_index,
   output logic [dsa_pkg::ADDR_W64-1:0]    rsp_cpu_address,
   output logic [dsa_pkg::ADDR_W64-1:0]    rsp_gpu_address,
   // configuration side
   input  logic                            csr_we,
   input  logic [dsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dsa_pkg::CSR_DAT_W-1:0]   csr_wdata
);

   localparam int ADDR_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > dsa_pkg::LIMIT_W) ? CNT_W : dsa_pkg::LIMIT_W;
   localparam int IDX_W  = (ADDR_W > dsa_pkg::SLOT_W) ? ADDR_W : dsa_pkg::SLOT_W;
   localparam int PROD_W = IDX_W + dsa_pkg::STRIDE_W;

   // configuration registers
   logic [dsa_pkg::LIMIT_W-1:0]  slot_limit_ff;
   logic [dsa_pkg::STRIDE_W-1:0] slot_stride_ff;
   logic [dsa_pkg::ADDR_W64-1:0] cpu_base_ff;
   logic [dsa_pkg::ADDR_W64-1:0] gpu_base_ff;
   logic                         shader_visible_ff;

   // allocator state
   dsa_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   fresh_ff, fresh_in;
   logic [CNT_W-1:0]   depth_ff, depth_in;
   logic [CNT_W-1:0]   active_ff, active_in;

   // allocate datapath
   logic               use_fresh_ff, use_fresh_in;
   logic [ADDR_W-1:0]  fresh_slot_ff, fresh_slot_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // result registers
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dsa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [dsa_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [dsa_pkg::ADDR_W64-1:0] rsp_cpu_ff, rsp_cpu_in;
   logic [dsa_pkg::ADDR_W64-1:0] rsp_gpu_ff, rsp_gpu_in;

   // free stack port signals
   logic                       push_en;
   logic                       pop_en;
   logic [CNT_W-1:0]           pop_ptr;
   logic [dsa_pkg::SLOT_W-1:0] pop_data;

   logic             accept;
   logic [CMP_W-1:0] limit_ext;
   logic [CMP_W-1:0] depth_cap;
   logic [CMP_W-1:0] eff_limit;
   logic             fresh_avail;
   logic [dsa_pkg::ADDR_W64-1:0] offset;

   // Free stack storage
   dsa_ram #(
      .WIDTH (dsa_pkg::SLOT_W),
      .DEPTH (HEAP_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (depth_ff[ADDR_W-1:0]),
      .wr_data (req_free_slot),
      .rd_en   (pop_en),
      .rd_addr (pop_ptr[ADDR_W-1:0]),
      .rd_data (pop_data)
   );

   assign accept = start && (state_ff == dsa_pkg::ST_IDLE);
   assign busy   = (state_ff != dsa_pkg::ST_IDLE);

   // Clip the configured limit to the built depth
   assign limit_ext   = CMP_W'(slot_limit_ff);
   assign depth_cap   = CMP_W'(HEAP_DEPTH);
   assign eff_limit   = (limit_ext < depth_cap) ? limit_ext : depth_cap;
   assign fresh_avail = CMP_W'(fresh_ff) < eff_limit;

   assign pop_ptr = depth_ff - CNT_W'(1);
   assign offset  = dsa_pkg::ADDR_W64'(prod_ff);

   // Sequence commands, update counters, build results
   always_comb begin
      state_in      = state_ff;
      fresh_in      = fresh_ff;
      depth_in      = depth_ff;
      active_in     = active_ff;
      use_fresh_in  = use_fresh_ff;
      fresh_slot_in = fresh_slot_ff;
      slot_in       = slot_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_cpu_in    = rsp_cpu_ff;
      rsp_gpu_in    = rsp_gpu_ff;
      push_en       = 1'b0;
      pop_en        = 1'b0;

      case (state_ff)
         dsa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_cmd == dsa_pkg::CMD_ALLOC) begin
                  if (fresh_avail) begin
                     // take the next never-used slot
                     use_fresh_in  = 1'b1;
                     fresh_slot_in = fresh_ff[ADDR_W-1:0];
                     fresh_in      = fresh_ff + CNT_W'(1);
                     active_in     = active_ff + CNT_W'(1);
                     state_in      = dsa_pkg::ST_FETCH;
                  end else if (depth_ff != '0) begin
                     // pop the most recently freed slot
                     use_fresh_in = 1'b0;
                     pop_en       = 1'b1;
                     depth_in     = pop_ptr;
                     active_in    = active_ff + CNT_W'(1);
                     state_in     = dsa_pkg::ST_FETCH;
                  end else begin
                     // heap exhausted: report and change nothing
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = dsa_pkg::STATUS_EXHAUSTED;
                     rsp_slot_in   = '0;
                     rsp_cpu_in    = '0;
                     rsp_gpu_in    = '0;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = '0;
                  rsp_cpu_in   = '0;
                  rsp_gpu_in   = '0;
                  if (active_ff == '0) begin
                     rsp_status_in = dsa_pkg::STATUS_NONE_ACTIVE;
                  end else begin
                     // push the returned slot; a full stack drops the word
                     rsp_status_in = dsa_pkg::STATUS_OK;
                     active_in     = active_ff - CNT_W'(1);
                     if (depth_ff < CNT_W'(HEAP_DEPTH)) begin
                        push_en  = 1'b1;
                        depth_in = depth_ff + CNT_W'(1);
                     end
                  end
               end
            end
         end
         dsa_pkg::ST_FETCH: begin
            // pick the slot and scale it by the stride
            if (use_fresh_ff) begin
               slot_in = IDX_W'(fresh_slot_ff);
            end else begin
               slot_in = IDX_W'(pop_data);
            end
            prod_in  = PROD_W'(slot_in) * PROD_W'(slot_stride_ff);
            state_in = dsa_pkg::ST_ADD;
         end
         dsa_pkg::ST_ADD: begin
            // add the bases and present the result
            rsp_valid_in  = 1'b1;
            rsp_status_in = dsa_pkg::STATUS_OK;
            rsp_slot_in   = slot_ff[dsa_pkg::SLOT_W-1:0];
            rsp_cpu_in    = cpu_base_ff + offset;
            rsp_gpu_in    = shader_visible_ff ? (gpu_base_ff + offset) : gpu_base_ff;
            state_in      = dsa_pkg::ST_IDLE;
         end
         default: begin
            state_in = dsa_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsa_pkg::ST_IDLE;
         fresh_ff     <= '0;
         depth_ff     <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         depth_ff     <= depth_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result words
   always_ff @(posedge clock) begin
      use_fresh_ff  <= use_fresh_in;
      fresh_slot_ff <= fresh_slot_in;
      slot_ff       <= slot_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_cpu_ff    <= rsp_cpu_in;
      rsp_gpu_ff    <= rsp_gpu_in;
   end

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_limit_ff     <= dsa_pkg::SLOT_LIMIT_RST;
         slot_stride_ff    <= dsa_pkg::SLOT_STRIDE_RST;
         cpu_base_ff       <= '0;
         gpu_base_ff       <= '0;
         shader_visible_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            dsa_pkg::REG_SLOT_LIMIT:     slot_limit_ff     <= csr_wdata[dsa_pkg::LIMIT_W-1:0];
            dsa_pkg::REG_SLOT_STRIDE:    slot_stride_ff    <= csr_wdata[dsa_pkg::STRIDE_W-1:0];
            dsa_pkg::REG_CPU_BASE:       cpu_base_ff       <= csr_wdata;
            dsa_pkg::REG_GPU_BASE:       gpu_base_ff       <= csr_wdata;
            dsa_pkg::REG_SHADER_VISIBLE: shader_visible_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_cpu_address = rsp_cpu_ff;
   assign rsp_gpu_address = rsp_gpu_ff;

endmodule

// File: src/dsa_checker.sv
// Port-level checker of the descriptor slot allocator and its bind.
module dsa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_cmd,
   input logic                          rsp_valid,
   input logic [dsa_pkg::STATUS_W-1:0]  rsp_status,
   input logic [dsa_pkg::SLOT_W-1:0]    rsp_slot_index,
   input logic [dsa_pkg::ADDR_W64-1:0]  rsp_cpu_address,
   input logic [dsa_pkg::ADDR_W64-1:0]  rsp_gpu_address
);

   // No result word carries the unused status code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != dsa_pkg::STATUS_UNUSED))
      else $error("result word with unused status code");

   // Error results carry zero fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != dsa_pkg::STATUS_OK)) |->
      ((rsp_slot_index == '0) && (rsp_cpu_address == '0) && (rsp_gpu_address == '0)))
      else $error("error result with nonzero fields");

   // A free is answered in the next cycle and never reports exhaustion
   a_free_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == dsa_pkg::CMD_FREE)) |=>
      (rsp_valid && (rsp_status != dsa_pkg::STATUS_EXHAUSTED)))
      else $error("free not answered next cycle");

   // Every free result carries zero fields too
   a_free_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == dsa_pkg::CMD_FREE)) |=>
      ((rsp_slot_index == '0) && (rsp_cpu_address == '0) && (rsp_gpu_address == '0)))
      else $error("free result with nonzero fields");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_cmd         (req_cmd),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_slot_index  (rsp_slot_index),
   .rsp_cpu_address (rsp_cpu_address),
   .rsp_gpu_address (rsp_gpu_address)
);

// File: verif/tb_top.sv
// Self-checking testbench for the descriptor slot allocator: bump slots, free stack, addresses.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HEAP_DEPTH  = dsa_pkg::HEAP_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SLOT_W      = dsa_pkg::SLOT_W;
   localparam int STATUS_W    = dsa_pkg::STATUS_W;
   localparam int ADDR_W64    = dsa_pkg::ADDR_W64;
   localparam int LIMIT_W     = dsa_pkg::LIMIT_W;
   localparam int STRIDE_W    = dsa_pkg::STRIDE_W;
   localparam int CSR_IDX_W   = dsa_pkg::CSR_IDX_W;
   localparam int CSR_DAT_W   = dsa_pkg::CSR_DAT_W;

   typedef struct packed {
      logic              cmd;
      logic [SLOT_W-1:0] free_slot;
   } cmd_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic [ADDR_W64-1:0] cpu_address;
      logic [ADDR_W64-1:0] gpu_address;
   } slot_result_type;

   // DUT ports, all inputs known from time zero
   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 start         = 1'b0;
   logic                 busy;
   logic                 req_cmd       = dsa_pkg::CMD_ALLOC;
   logic [SLOT_W-1:0]    req_free_slot = '0;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SLOT_W-1:0]    rsp_slot_index;
   logic [ADDR_W64-1:0]  rsp_cpu_address;
   logic [ADDR_W64-1:0]  rsp_gpu_address;
   logic                 csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = dsa_pkg::REG_SLOT_LIMIT;
   logic [CSR_DAT_W-1:0] csr_wdata     = '0;

   // Shadow of the configuration registers
   logic [LIMIT_W-1:0]   limit_reg  = dsa_pkg::SLOT_LIMIT_RST;
   logic [STRIDE_W-1:0]  stride_reg = dsa_pkg::SLOT_STRIDE_RST;
   logic [ADDR_W64-1:0]  cpu_base_reg = '0;
   logic [ADDR_W64-1:0]  gpu_base_reg = '0;
   logic                 visible_reg  = 1'b0;

   // Shadow of the allocator state
   logic [LIMIT_W-1:0]   fresh_index  = '0;
   logic [LIMIT_W-1:0]   free_depth   = '0;
   logic [LIMIT_W-1:0]   active_slots = '0;
   logic [SLOT_W-1:0]    free_stack [HEAP_DEPTH];

   cmd_word_type    pending_words [$];
   slot_result_type expected_results [$];
   int              fail_count  = 0;
   int              cycle_count = 0;
   int              burst_left  = 0;
   int              gap_left    = 0;

   descriptor_slot_allocator #(.HEAP_DEPTH(HEAP_DEPTH)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_free_slot   (req_free_slot),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_cpu_address (rsp_cpu_address),
      .rsp_gpu_address (rsp_gpu_address),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Work out the result of one accepted word and advance the shadow state
   task automatic predict_slot_grant(input cmd_word_type w);
      slot_result_type     r;
      logic [LIMIT_W-1:0]  eff_limit;
      logic [SLOT_W-1:0]   slot;
      logic                got;
      logic [ADDR_W64-1:0] offset;
      r = '0;
      got = 1'b0;
      slot = '0;
      eff_limit = (limit_reg < LIMIT_W'(HEAP_DEPTH)) ? limit_reg : LIMIT_W'(HEAP_DEPTH);
      if (w.cmd == dsa_pkg::CMD_ALLOC) begin
         // bump first, then reuse the most recently freed slot
         if (fresh_index < eff_limit) begin
            slot = fresh_index[SLOT_W-1:0];
            fresh_index = fresh_index + 1'b1;
            got = 1'b1;
         end else if (free_depth != 0) begin
            free_depth = free_depth - 1'b1;
            slot = free_stack[free_depth[SLOT_W-1:0]];
            got = 1'b1;
         end
         if (got) begin
            offset = ADDR_W64'(slot) * ADDR_W64'(stride_reg);
            active_slots = active_slots + 1'b1;
            r.slot_index  = slot;
            r.cpu_address = cpu_base_reg + offset;
            r.gpu_address = visible_reg ? gpu_base_reg + offset : gpu_base_reg;
         end else begin
            r.status = dsa_pkg::STATUS_EXHAUSTED;
         end
      end else begin
         if (active_slots == 0) begin
            r.status = dsa_pkg::STATUS_NONE_ACTIVE;
         end else begin
            // push without any check on the index; drop on a full stack
            if (free_depth < LIMIT_W'(HEAP_DEPTH)) begin
               free_stack[free_depth[SLOT_W-1:0]] = w.free_slot;
               free_depth = free_depth + 1'b1;
            end
            active_slots = active_slots - 1'b1;
         end
      end
      expected_results = {expected_results, r};
   endtask

   // Write one register and mirror it in the shadow
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         dsa_pkg::REG_SLOT_LIMIT:     limit_reg    = data[LIMIT_W-1:0];
         dsa_pkg::REG_SLOT_STRIDE:    stride_reg   = data[STRIDE_W-1:0];
         dsa_pkg::REG_CPU_BASE:       cpu_base_reg = data;
         dsa_pkg::REG_GPU_BASE:       gpu_base_reg = data;
         dsa_pkg::REG_SHADER_VISIBLE: visible_reg  = data[0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [LIMIT_W-1:0] lim, input logic [STRIDE_W-1:0] stride,
                            input logic [ADDR_W64-1:0] cpu, input logic [ADDR_W64-1:0] gpu,
                            input logic vis);
      write_reg(dsa_pkg::REG_SLOT_LIMIT, CSR_DAT_W'(lim));
      write_reg(dsa_pkg::REG_SLOT_STRIDE, CSR_DAT_W'(stride));
      write_reg(dsa_pkg::REG_CPU_BASE, cpu);
      write_reg(dsa_pkg::REG_GPU_BASE, gpu);
      write_reg(dsa_pkg::REG_SHADER_VISIBLE, CSR_DAT_W'(vis));
   endtask

   task automatic add_word(input logic cmd, input logic [SLOT_W-1:0] slot);
      cmd_word_type w;
      w.cmd = cmd;
      w.free_slot = slot;
      pending_words = {pending_words, w};
   endtask

   // Hold until every word is taken and answered, then let the pipeline drain
   task automatic wait_idle();
      while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [ADDR_W64-1:0] pick_base();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [STRIDE_W-1:0] pick_stride();
      case ($urandom_range(0, 3))
         0:       return 16'd1;
         1:       return 16'hFFFF;
         default: return STRIDE_W'($urandom_range(1, 65535));
      endcase
   endfunction

   // Stimulus: directed checks, then random phases under changing settings
   initial begin
      logic [LIMIT_W-1:0] lim;
      logic               grow;
      int                 run_left;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: free with nothing active, fresh slots, free of the top index
      add_word(dsa_pkg::CMD_FREE, 12'hFFF);
      add_word(dsa_pkg::CMD_ALLOC, 12'h000);
      add_word(dsa_pkg::CMD_FREE, 12'hFFF);
      add_word(dsa_pkg::CMD_ALLOC, 12'hFFF);
      wait_idle();

      // limit zero and below the bump index: only the free stack serves; addresses wrap
      write_all(13'd0, 16'hFFFF, '1, 64'hFFFF_FFFF_FFFF_0000, 1'b1);
      add_word(dsa_pkg::CMD_ALLOC, 12'h000);
      add_word(dsa_pkg::CMD_ALLOC, 12'h000);
      add_word(dsa_pkg::CMD_FREE, 12'h000);
      add_word(dsa_pkg::CMD_FREE, 12'h000);
      add_word(dsa_pkg::CMD_FREE, 12'h005);
      add_word(dsa_pkg::CMD_ALLOC, 12'hFFF);
      add_word(dsa_pkg::CMD_ALLOC, 12'h000);
      add_word(dsa_pkg::CMD_ALLOC, 12'h000);
      wait_idle();

      // limit above the built depth
      write_all(13'h1FFF, 16'd1, '0, '1, 1'b1);
      add_word(dsa_pkg::CMD_ALLOC, 12'h000);
      add_word(dsa_pkg::CMD_ALLOC, 12'h000);
      add_word(dsa_pkg::CMD_FREE, 12'hFFF);
      add_word(dsa_pkg::CMD_FREE, 12'hFFF);
      wait_idle();

      // random phases: alternate growing and shrinking runs
      grow = 1'b1;
      run_left = 0;
      for (int p = 0; p < 6; p++) begin
         if (p == 2) begin
            lim = LIMIT_W'(HEAP_DEPTH);
         end else if ($urandom_range(0, 3) == 0) begin
            lim = LIMIT_W'($urandom_range(0, fresh_index));
         end else begin
            lim = fresh_index + LIMIT_W'($urandom_range(1, 24));
         end
         write_all(lim, pick_stride(), pick_base(), pick_base(), 1'($urandom_range(0, 1)));
         for (int n = 0; n < 122; n++) begin
            if (run_left == 0) begin
               grow = ~grow;
               run_left = $urandom_range(4, 30);
            end
            run_left--;
            if ($urandom_range(0, 99) < (grow ? 85 : 15)) begin
               add_word(dsa_pkg::CMD_ALLOC, SLOT_W'($urandom_range(0, 4095)));
            end else if ($urandom_range(0, 2) == 0) begin
               add_word(dsa_pkg::CMD_FREE, SLOT_W'($urandom_range(0, 4095)));
            end else begin
               add_word(dsa_pkg::CMD_FREE, SLOT_W'($urandom_range(0, 31)));
            end
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("[descriptor_slot_allocator] OK");
      end else begin
         $display("[descriptor_slot_allocator] ERROR");
      end
      $finish;
   end

   // Driver: present the oldest pending word, in bursts with random gaps
   always @(posedge clock) begin : word_driver
      logic go;
      go = 1'b0;
      if (reset) begin
         start <= 1'b0;
         burst_left = $urandom_range(1, 32);
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            predict_slot_grant(pending_words.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 32);
               gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_words.size() != 0) begin
            go = 1'b1;
         end
         start <= go;
         if (go) begin
            req_cmd       <= pending_words[0].cmd;
            req_free_slot <= pending_words[0].free_slot;
         end
      end
   end

   // Monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin : result_monitor
      slot_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected result: status %0d slot %0d cpu %h gpu %h",
                        rsp_status, rsp_slot_index, rsp_cpu_address, rsp_gpu_address);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status || rsp_slot_index !== want.slot_index ||
                rsp_cpu_address !== want.cpu_address ||
                rsp_gpu_address !== want.gpu_address) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch: expected status %0d slot %0d cpu %h gpu %h",
                           want.status, want.slot_index, want.cpu_address, want.gpu_address);
                  $display("          actual   status %0d slot %0d cpu %h gpu %h",
                           rsp_status, rsp_slot_index, rsp_cpu_address, rsp_gpu_address);
               end
            end
         end
      end
   end

   // Watchdog on the whole run
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[descriptor_slot_allocator] ERROR");
         $finish;
      end
   end

endmodule
